[hdl/gwl_pkg.sv]
`timescale 1ns / 1ps

package gwl_pkg;

  localparam int PIX_W     = 16;
  localparam int GRAY_W    = 8;
  localparam int DIV_STEPS = GRAY_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  // (p - lo) * 255 * 2 + den stays below 2^25
  localparam int NUM_W     = PIX_W + GRAY_W;
  localparam int REM_W     = NUM_W + 1;
  localparam int DSH_W     = PIX_W + 1 + (DIV_STEPS - 1);
  localparam int ADDR_W    = 4;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  localparam logic [1:0] REG_WINDOW_LOW  = 2'd0;
  localparam logic [1:0] REG_WINDOW_HIGH = 2'd1;
  localparam logic [1:0] REG_EXCL_SAT    = 2'd2;

  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } in_word_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray8;
    logic [PIX_W-1:0]  raw_pixel;
    logic              range_error;
    logic              frame_end_out;
  } out_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] window_low;
    logic [PIX_W-1:0] window_high;
    logic             exclude_saturated;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/gray16_window_to_gray8_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           word
// in_       input      in_valid/in_stall   in_word_t  (req_type, pixel, frame_end)
// out_      output     out_valid/out_stall out_word_t (gray8, raw_pixel, range_error,
//                                                      frame_end_out)
// cfg       input      apb psel/penable    window_low, window_high, exclude_saturated
//
// a measure word is done on acceptance; a convert word that is clamped or in error
// reaches the output register in the cycle after acceptance
// an in-window convert word enters the restoring divider on acceptance, gets
// one quotient bit a cycle in ST_DIV, and in ST_FIN loads the free output register
// synchronous active-low reset clears the window registers and control state
// a stalled output holds its word; input is stalled while a word is at work
// or the output register is full and not being drained

module gray16_window_to_gray8_top
  import gwl_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_LOW:  cfg_r.window_low        <= pwdata[PIX_W-1:0];
        REG_WINDOW_HIGH: cfg_r.window_high       <= pwdata[PIX_W-1:0];
        REG_EXCL_SAT:    cfg_r.exclude_saturated <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LOW:  prdata = 32'(cfg_r.window_low);
      REG_WINDOW_HIGH: prdata = 32'(cfg_r.window_high);
      REG_EXCL_SAT:    prdata = 32'(cfg_r.exclude_saturated);
      default:         prdata = '0;
    endcase
  end

  gwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gwl_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[hdl/gwl_ctrl.sv]
`timescale 1ns / 1ps

module gwl_ctrl
  import gwl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   idle;

  assign idle     = (state_r == ST_IDLE);
  assign in_stall = !(idle && sts.out_free);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid && sts.out_free;
        if (cmd.take && sts.needs_div) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/gwl_dp.sv]
`timescale 1ns / 1ps

module gwl_dp
  import gwl_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_word_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_data,
  input  cmd_t      cmd,
  output sts_t      sts
);

  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  logic [PIX_W-1:0] running_low_r, running_high_r;
  logic [PIX_W-1:0] measured_low_r, measured_high_r;
  logic [PIX_W-1:0] run_low_nxt, run_high_nxt;

  logic [PIX_W-1:0] pix, lo, hi, diff, den;
  logic             auto_rng, rng_err, is_conv;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] dividend;

  logic [REM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [GRAY_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PIX_W-1:0]  pix_r;
  logic              fe_r;
  logic              sub_ok;

  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t triv_word;

  assign pix      = in_data.pixel & PIX_MAX;
  assign is_conv  = (in_data.req_type == REQ_CONVERT);

  // configured window, or the measured range when low equals high or high is zero
  assign auto_rng = (cfg.window_low == cfg.window_high) || (cfg.window_high == '0);
  assign lo       = auto_rng ? measured_low_r  : cfg.window_low;
  assign hi       = auto_rng ? measured_high_r : cfg.window_high;
  assign rng_err  = (hi <= lo);

  // rounded quotient of (2*255*(p-lo) + den) / (2*den)
  assign diff     = pix - lo;
  assign den      = hi - lo;
  assign num      = {diff, 8'd0} - NUM_W'(diff);
  assign dividend = {num, 1'b0} + REM_W'(den);

  assign sts.needs_div = is_conv && !rng_err && (pix > lo) && (pix < hi);
  assign sts.div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    triv_word.raw_pixel     = pix;
    triv_word.range_error   = rng_err;
    triv_word.frame_end_out = in_data.frame_end;
    if (rng_err || pix <= lo) begin
      triv_word.gray8 = '0;
    end else begin
      triv_word.gray8 = GRAY_MAX;
    end
  end

  always_comb begin
    run_low_nxt  = running_low_r;
    run_high_nxt = running_high_r;
    if (!(cfg.exclude_saturated && pix == '0) && pix < running_low_r) begin
      run_low_nxt = pix;
    end
    if (!(cfg.exclude_saturated && pix == PIX_MAX) && pix > running_high_r) begin
      run_high_nxt = pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_low_r   <= PIX_MAX;
      running_high_r  <= '0;
      measured_low_r  <= PIX_MAX;
      measured_high_r <= '0;
    end else if (cmd.take && !is_conv) begin
      if (in_data.frame_end) begin
        measured_low_r  <= run_low_nxt;
        measured_high_r <= run_high_nxt;
        running_low_r   <= PIX_MAX;
        running_high_r  <= '0;
      end else begin
        running_low_r  <= run_low_nxt;
        running_high_r <= run_high_nxt;
      end
    end
  end

  assign sub_ok = (rem_r >= REM_W'(dsh_r));

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rem_r <= dividend;
      dsh_r <= {den, 1'b0, (DIV_STEPS - 1)'(0)};
      q_r   <= '0;
      cnt_r <= '0;
      pix_r <= pix;
      fe_r  <= in_data.frame_end;
    end else if (cmd.div_step) begin
      if (sub_ok) begin
        rem_r <= rem_r - REM_W'(dsh_r);
      end
      q_r   <= {q_r[GRAY_W-2:0], sub_ok};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.gray8         <= q_r;
      out_data_r.raw_pixel     <= pix_r;
      out_data_r.range_error   <= 1'b0;
      out_data_r.frame_end_out <= fe_r;
    end else if (cmd.take && is_conv && !sts.needs_div) begin
      out_data_r <= triv_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out || (cmd.take && is_conv && !sts.needs_div)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
